[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is held.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define AST_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/wmpm_pkg.sv]
`default_nettype none
package wmpm_pkg;

  localparam int MAX_NODES   = 256;
  localparam int ALPHABET    = 20;
  localparam int WEIGHT_BITS = 18;
  localparam int NODE_W      = 8;
  localparam int SYM_W       = 5;
  localparam int W_IN_W      = 10;
  localparam int OP_W        = 2;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int CADDR_W     = $clog2(CHILD_DEPTH);
  localparam int QPTR_W      = NODE_W + 1;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 32;
  localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_BUILD   = 2'd1,
    OP_MATCH   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE,
    ST_I_RD, ST_I_CHK, ST_I_WRD, ST_I_WADD,
    ST_M_START, ST_M_END, ST_RESTART,
    ST_W_RD, ST_W_CHK,
    ST_B_INIT, ST_B_POP, ST_B_N, ST_B_PRD, ST_B_PCHK, ST_B_PF,
    ST_B_SETF, ST_B_WN, ST_B_WADD, ST_B_SRD, ST_B_SCHK, ST_B_END,
    ST_OUT_RD, ST_OUT_LD
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR, CMD_LOAD,
    CMD_I_RD, CMD_I_CHK, CMD_I_WRD, CMD_I_WADD,
    CMD_M_START, CMD_M_END, CMD_RESTART,
    CMD_W_RD, CMD_W_CHK,
    CMD_B_INIT, CMD_B_POP, CMD_B_N, CMD_B_PRD, CMD_B_PCHK, CMD_B_PF,
    CMD_B_SETF, CMD_B_WN, CMD_B_WADD, CMD_B_SRD, CMD_B_SCHK, CMD_B_END,
    CMD_OUT_RD, CMD_OUT_LD
  } cmd_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic clr_done;
    logic ins_ok;
    logic ins_last;
    logic walk_kid;
    logic walk_more;
    logic op_build;
    logic q_empty;
    logic q_root;
    logic par_root;
    logic n_root;
    logic scan_done;
    logic out_busy;
  } stat_t;

  function automatic logic [WEIGHT_BITS-1:0] sat_add(input logic [WEIGHT_BITS-1:0] a,
                                                     input logic [WEIGHT_BITS-1:0] b);
    logic [WEIGHT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WEIGHT_BITS] ? {WEIGHT_BITS{1'b1}} : s[WEIGHT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/wmpm_ctrl.sv]
`default_nettype none
module wmpm_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  input  wire logic [wmpm_pkg::OP_W-1:0] in_op,
  input  wire wmpm_pkg::stat_t         st,
  output wmpm_pkg::cmd_t               cmd,
  output logic                         in_tready
);
  import wmpm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:     if (st.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          case (op_t'(in_op))
            OP_INSERT: state_nxt = ST_I_RD;
            OP_BUILD:  state_nxt = ST_B_INIT;
            OP_MATCH:  state_nxt = ST_M_START;
            default:   state_nxt = ST_RESTART;
          endcase
        end
      end
      ST_I_RD:    state_nxt = ST_I_CHK;
      ST_I_CHK:   state_nxt = (st.ins_ok && st.ins_last) ? ST_I_WRD : ST_OUT_RD;
      ST_I_WRD:   state_nxt = ST_I_WADD;
      ST_I_WADD:  state_nxt = ST_OUT_RD;
      ST_M_START: state_nxt = ST_W_RD;
      ST_W_RD:    state_nxt = ST_W_CHK;
      ST_W_CHK: begin
        if (st.walk_kid || !st.walk_more) begin
          state_nxt = st.op_build ? ST_B_SETF : ST_M_END;
        end else begin
          state_nxt = ST_W_RD;
        end
      end
      ST_M_END:   state_nxt = ST_OUT_RD;
      ST_RESTART: state_nxt = ST_OUT_RD;
      ST_B_INIT:  state_nxt = ST_B_POP;
      ST_B_POP:   state_nxt = st.q_empty ? ST_B_END : ST_B_N;
      ST_B_N:     state_nxt = st.q_root ? ST_B_SETF : ST_B_PRD;
      ST_B_PRD:   state_nxt = ST_B_PCHK;
      ST_B_PCHK:  state_nxt = st.par_root ? ST_B_SETF : ST_B_PF;
      ST_B_PF:    state_nxt = ST_W_RD;
      ST_B_SETF:  state_nxt = st.n_root ? ST_B_SRD : ST_B_WN;
      ST_B_WN:    state_nxt = ST_B_WADD;
      ST_B_WADD:  state_nxt = ST_B_SRD;
      ST_B_SRD:   state_nxt = ST_B_SCHK;
      ST_B_SCHK:  state_nxt = st.scan_done ? ST_B_POP : ST_B_SRD;
      ST_B_END:   state_nxt = ST_OUT_RD;
      ST_OUT_RD:  state_nxt = ST_OUT_LD;
      ST_OUT_LD:  if (!st.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLR;
    endcase
  end

  // command outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = CMD_NONE;
    case (state_r)
      ST_CLR:     cmd = CMD_CLR;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd       = in_tvalid ? CMD_LOAD : CMD_NONE;
      end
      ST_I_RD:    cmd = CMD_I_RD;
      ST_I_CHK:   cmd = CMD_I_CHK;
      ST_I_WRD:   cmd = CMD_I_WRD;
      ST_I_WADD:  cmd = CMD_I_WADD;
      ST_M_START: cmd = CMD_M_START;
      ST_M_END:   cmd = CMD_M_END;
      ST_RESTART: cmd = CMD_RESTART;
      ST_W_RD:    cmd = CMD_W_RD;
      ST_W_CHK:   cmd = CMD_W_CHK;
      ST_B_INIT:  cmd = CMD_B_INIT;
      ST_B_POP:   cmd = CMD_B_POP;
      ST_B_N:     cmd = CMD_B_N;
      ST_B_PRD:   cmd = CMD_B_PRD;
      ST_B_PCHK:  cmd = CMD_B_PCHK;
      ST_B_PF:    cmd = CMD_B_PF;
      ST_B_SETF:  cmd = CMD_B_SETF;
      ST_B_WN:    cmd = CMD_B_WN;
      ST_B_WADD:  cmd = CMD_B_WADD;
      ST_B_SRD:   cmd = CMD_B_SRD;
      ST_B_SCHK:  cmd = CMD_B_SCHK;
      ST_B_END:   cmd = CMD_B_END;
      ST_OUT_RD:  cmd = CMD_OUT_RD;
      ST_OUT_LD:  cmd = CMD_OUT_LD;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/wmpm_dp.sv]
`default_nettype none
module wmpm_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire wmpm_pkg::cmd_t                   cmd,
  input  wire logic [wmpm_pkg::OP_W-1:0]        in_op,
  input  wire logic [wmpm_pkg::SYM_W-1:0]       in_sym,
  input  wire logic                             in_last,
  input  wire logic [wmpm_pkg::W_IN_W-1:0]      in_w,
  input  wire logic                             out_tready,
  output wmpm_pkg::stat_t                       st,
  output logic                                  out_valid,
  output logic [wmpm_pkg::NODE_W-1:0]           out_node,
  output logic [wmpm_pkg::WEIGHT_BITS-1:0]      out_weight,
  output logic                                  out_status
);
  import wmpm_pkg::*;

  // memories
  logic [NODE_W-1:0]      child_mem [0:CHILD_DEPTH-1];
  logic [WEIGHT_BITS-1:0] wt_mem    [0:MAX_NODES-1];
  logic [NODE_W-1:0]      fail_mem  [0:MAX_NODES-1];
  logic [NODE_W-1:0]      par_mem   [0:MAX_NODES-1];
  logic [SYM_W-1:0]       let_mem   [0:MAX_NODES-1];
  logic [NODE_W-1:0]      que_mem   [0:MAX_NODES-1];

  logic [NODE_W-1:0]      child_q, fail_q, par_q, que_q;
  logic [SYM_W-1:0]       let_q;
  logic [WEIGHT_BITS-1:0] wt_q;

  // control and work registers
  logic [CADDR_W-1:0]     clr_r;
  logic [NODE_W-1:0]      ncnt_r, icur_r, match_r;
  logic [QPTR_W-1:0]      head_r, tail_r, guard_r;
  logic [NODE_W-1:0]      cur_r, n_r, node_r;
  logic [SYM_W-1:0]       wsym_r, s_r, sym_r, let_r;
  logic [OP_W-1:0]        op_r;
  logic                   last_r, status_r;
  logic [W_IN_W-1:0]      w_r;
  logic [WEIGHT_BITS-1:0] fw_r;

  logic [NODE_W-1:0]      ca_node;
  logic [SYM_W-1:0]       ca_sym;
  logic [CADDR_W-1:0]     caddr;
  logic                   c_we;
  logic [CADDR_W-1:0]     c_wa;
  logic [NODE_W-1:0]      c_wd;
  logic [NODE_W-1:0]      wt_ra, wt_wa, fail_ra;
  logic                   wt_we;
  logic [WEIGHT_BITS-1:0] wt_wd;
  logic                   ins_sym_ok, ins_kid, can_alloc, walk_kid;
  logic [NODE_W-1:0]      new_node;
  logic                   out_busy;

  assign ins_sym_ok = sym_r < SYM_W'(ALPHABET);
  assign ins_kid    = ins_sym_ok && (child_q != '0);
  assign can_alloc  = ins_sym_ok && (ncnt_r < NODE_W'(MAX_NODES - 1));
  assign new_node   = ncnt_r + NODE_W'(1);
  assign walk_kid   = (wsym_r < SYM_W'(ALPHABET)) && (child_q != '0);
  assign out_busy   = out_valid && !out_tready;

  // child table address: node * ALPHABET + symbol
  always_comb begin
    ca_node = cur_r;
    ca_sym  = wsym_r;
    case (cmd)
      CMD_I_RD, CMD_I_CHK: begin
        ca_node = icur_r;
        ca_sym  = sym_r;
      end
      CMD_B_SRD: begin
        ca_node = n_r;
        ca_sym  = s_r;
      end
      default: begin
        ca_node = cur_r;
        ca_sym  = wsym_r;
      end
    endcase
  end
  assign caddr = CADDR_W'(ca_node * ALPHABET) + CADDR_W'(ca_sym);

  // child table write
  always_comb begin
    c_we = 1'b0;
    c_wa = caddr;
    c_wd = new_node;
    case (cmd)
      CMD_CLR: begin
        c_we = 1'b1;
        c_wa = clr_r;
        c_wd = '0;
      end
      CMD_I_CHK: c_we = !ins_kid && can_alloc;
      default:   c_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) child_mem[c_wa] <= c_wd;
    child_q <= child_mem[caddr];
  end

  // weight memory ports
  always_comb begin
    wt_ra = node_r;
    wt_we = 1'b0;
    wt_wa = node_r;
    wt_wd = sat_add(wt_q, WEIGHT_BITS'(w_r));
    case (cmd)
      CMD_B_SETF: wt_ra = cur_r;
      CMD_B_WN:   wt_ra = n_r;
      CMD_CLR: begin
        wt_we = clr_r < CADDR_W'(MAX_NODES);
        wt_wa = clr_r[NODE_W-1:0];
        wt_wd = '0;
      end
      CMD_I_WADD: wt_we = 1'b1;
      CMD_B_WADD: begin
        wt_we = 1'b1;
        wt_wa = n_r;
        wt_wd = sat_add(wt_q, fw_r);
      end
      default: wt_ra = node_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_q <= wt_mem[wt_ra];
  end

  // failure links
  assign fail_ra = (cmd == CMD_B_PCHK) ? par_q : cur_r;
  always_ff @(posedge clk) begin
    if (cmd == CMD_B_SETF) fail_mem[n_r] <= cur_r;
    fail_q <= fail_mem[fail_ra];
  end

  // parent and letter of each node
  always_ff @(posedge clk) begin
    if (cmd == CMD_I_CHK && !ins_kid && can_alloc) begin
      par_mem[new_node] <= icur_r;
      let_mem[new_node] <= sym_r;
    end
    par_q <= par_mem[n_r];
    let_q <= let_mem[n_r];
  end

  // breadth-first queue
  always_ff @(posedge clk) begin
    if (cmd == CMD_B_INIT) begin
      que_mem[0] <= ROOT;
    end else if (cmd == CMD_B_SCHK && child_q != '0 && tail_r < QPTR_W'(MAX_NODES)) begin
      que_mem[tail_r[NODE_W-1:0]] <= child_q;
    end
    que_q <= que_mem[head_r[NODE_W-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      ncnt_r    <= ROOT;
      icur_r    <= ROOT;
      match_r   <= ROOT;
      head_r    <= '0;
      tail_r    <= '0;
      guard_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result wins over the hand-off of the old one
      if (cmd == CMD_OUT_LD && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_tready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        CMD_CLR: clr_r <= clr_r + CADDR_W'(1);
        CMD_I_CHK: begin
          if (!ins_kid && can_alloc) ncnt_r <= new_node;
          if ((ins_kid || can_alloc) && !last_r) begin
            icur_r <= ins_kid ? child_q : new_node;
          end else begin
            icur_r <= ROOT;
          end
        end
        CMD_M_START, CMD_B_PF: guard_r <= '0;
        CMD_W_CHK: if (!walk_kid) guard_r <= guard_r + QPTR_W'(1);
        CMD_M_END:   match_r <= cur_r;
        CMD_RESTART: match_r <= ROOT;
        CMD_B_INIT: begin
          head_r <= '0;
          tail_r <= QPTR_W'(1);
        end
        CMD_B_POP: if (head_r != tail_r) head_r <= head_r + QPTR_W'(1);
        CMD_B_SCHK: begin
          if (child_q != '0 && tail_r < QPTR_W'(MAX_NODES)) tail_r <= tail_r + QPTR_W'(1);
        end
        default: ;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_r   <= in_op;
        sym_r  <= in_sym;
        last_r <= in_last;
        w_r    <= in_w;
      end
      CMD_I_CHK: begin
        if (ins_kid || can_alloc) begin
          node_r   <= ins_kid ? child_q : new_node;
          status_r <= 1'b0;
        end else begin
          node_r   <= ROOT;
          status_r <= 1'b1;
        end
      end
      CMD_M_START: begin
        cur_r  <= match_r;
        wsym_r <= sym_r;
      end
      CMD_W_CHK: begin
        if (walk_kid) begin
          cur_r <= child_q;
        end else if (cur_r > ROOT && guard_r < QPTR_W'(MAX_NODES)) begin
          cur_r <= fail_q;
        end
      end
      CMD_M_END: begin
        node_r   <= cur_r;
        status_r <= 1'b0;
      end
      CMD_RESTART, CMD_B_END: begin
        node_r   <= ROOT;
        status_r <= 1'b0;
      end
      CMD_B_N: begin
        n_r <= que_q;
        if (que_q == ROOT) cur_r <= ROOT;
      end
      CMD_B_PCHK: begin
        let_r <= let_q;
        if (par_q == ROOT) cur_r <= ROOT;
      end
      CMD_B_PF: begin
        cur_r  <= fail_q;
        wsym_r <= let_r;
      end
      CMD_B_SETF: s_r <= '0;
      CMD_B_WN:   fw_r <= wt_q;
      CMD_B_SCHK: s_r <= s_r + SYM_W'(1);
      CMD_OUT_LD: begin
        if (!out_busy) begin
          out_node   <= node_r;
          out_weight <= wt_q;
          out_status <= status_r;
        end
      end
      default: ;
    endcase
  end

  // flags
  always_comb begin
    st.clr_done  = clr_r == CADDR_W'(CHILD_DEPTH - 1);
    st.ins_ok    = ins_kid || can_alloc;
    st.ins_last  = last_r;
    st.walk_kid  = walk_kid;
    st.walk_more = (cur_r > ROOT) && (guard_r < QPTR_W'(MAX_NODES));
    st.op_build  = op_t'(op_r) == OP_BUILD;
    st.q_empty   = head_r == tail_r;
    st.q_root    = que_q == ROOT;
    st.par_root  = par_q == ROOT;
    st.n_root    = n_r == ROOT;
    st.scan_done = s_r == SYM_W'(ALPHABET - 1);
    st.out_busy  = out_busy;
  end

endmodule
`default_nettype wire

[hw/rtl/weighted_multi_pattern_matcher_core.sv]
`default_nettype none
// Weighted Aho-Corasick matcher. After reset the block sweeps its 5120-entry
// child table (and the 256 node weights) to zero, one entry per cycle, and
// holds in_tready low until the sweep is done. Each request then runs alone
// through the sequencer. Insert reads and checks one child slot and, when
// it ends a pattern, also adds its weight to the node. Match reads a child
// slot once more for each failure link followed; restart resets the match
// state to the root. Build handles the root, each node under the root and
// each deeper node, whose failure search may follow further links, and
// scans each node's 20 child slots in turn through the single child table
// port. A finished result sits in the output register while the next
// request is taken; a result still unread when the next one is ready holds
// the sequencer until out_tready. in_tdata: symbol [4:0], weight [14:5];
// in_tuser: op; in_tlast: pattern end. out_tdata: node [7:0],
// match_weight [25:8]; out_tuser: status (1 = insert dropped).
module weighted_multi_pattern_matcher_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [wmpm_pkg::IN_DATA_W-1:0]  in_tdata,   // symbol[4:0], weight[14:5], zero pad
  input  wire logic [1:0]                      in_tuser,   // op[1:0]
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [wmpm_pkg::OUT_DATA_W-1:0]      out_tdata,  // node[7:0], match_weight[25:8], pad
  output logic                                 out_tuser   // status
);
  import wmpm_pkg::*;

  cmd_t                   cmd;
  stat_t                  st;
  logic [NODE_W-1:0]      o_node;
  logic [WEIGHT_BITS-1:0] o_weight;

  wmpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .st        (st),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  wmpm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser),
    .in_sym     (in_tdata[SYM_W-1:0]),
    .in_last    (in_tlast),
    .in_w       (in_tdata[SYM_W+W_IN_W-1:SYM_W]),
    .out_tready (out_tready),
    .st         (st),
    .out_valid  (out_tvalid),
    .out_node   (o_node),
    .out_weight (o_weight),
    .out_status (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W - NODE_W - WEIGHT_BITS){1'b0}}, o_weight, o_node};

endmodule
`default_nettype wire

[hw/rtl/wmpm_chk.sv]
`default_nettype none
`include "assert_macros.svh"
module wmpm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result holds
  `AST_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed under stall")
  // the table sweep after reset blocks requests
  `AST_RAW(a_clr_block, !rst_n |=> !in_tready, "request taken during table sweep")
  // one request at a time
  `AST_CLK(a_one_req, in_tvalid && in_tready |=> !in_tready, "second request taken while busy")
  // a dropped insert reports the root
  `AST_CLK(a_drop_root, out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd1, "dropped insert not at root")

endmodule

bind weighted_multi_pattern_matcher_core wmpm_chk u_wmpm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
